// File: rtl/adzrs_pkg.sv
// shared widths, constants and divider transaction type for the axis range scaler
package adzrs_pkg;

    localparam int AXIS_W  = 16;
    localparam int MAG_W   = 15;
    localparam int DZ_W    = 14;
    localparam int RANGE_W = 18;
    localparam int SUM_W   = RANGE_W + 1;
    localparam int N_W     = 29;
    localparam int DIV_W   = N_W + 1;
    localparam int REM_W   = 48;
    localparam int PROD_W  = REM_W + 1;
    localparam int QUO_W   = 18;

    localparam logic [MAG_W-1:0] AXIS_FULL = 15'd32767;
    localparam logic [DZ_W-1:0]  DZ_FULL   = 14'd10000;
    localparam logic [QUO_W-1:0] QUO_MAX   = 18'd131072;

    localparam logic [1:0] REG_DEAD_ZONE = 2'd0;
    localparam logic [1:0] REG_RANGE_MIN = 2'd1;
    localparam logic [1:0] REG_RANGE_MAX = 2'd2;

    typedef struct packed {
        logic             neg;
        logic [REM_W-1:0] rem;
        logic [DIV_W-1:0] div;
        logic [QUO_W-1:0] quo;
    } t_div_data;

endpackage

// File: rtl/adzrs_front.sv
// front stages: sample magnitude, dead zone test, numerator and divisor setup
module adzrs_front
    import adzrs_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_mode,
    input  logic signed [AXIS_W-1:0]  i_axis_value,
    input  logic [MAG_W-1:0]          i_left_trigger,
    input  logic [MAG_W-1:0]          i_right_trigger,
    input  logic [DZ_W-1:0]           i_dead_zone,
    input  logic signed [RANGE_W-1:0] i_range_min,
    input  logic signed [RANGE_W-1:0] i_range_max,
    output logic                      o_valid,
    input  logic                      i_ready,
    output t_div_data                 o_data
);

    // stage a: signed sample to clamped magnitude
    logic                     r_a_valid;
    logic [MAG_W-1:0]         r_a_m;
    logic                     r_a_neg;
    // stage b: dead zone test and rational terms
    logic                     r_b_valid;
    logic                     r_b_dead;
    logic [N_W-1:0]           r_b_n;
    logic [N_W-1:0]           r_b_q;
    logic                     r_b_neg;
    // stage c: products
    logic                     r_c_valid;
    logic signed [PROD_W-1:0] r_c_p1;
    logic signed [PROD_W-1:0] r_c_p2;
    logic [DIV_W-1:0]         r_c_div;
    logic                     r_c_neg;
    // stage d: numerator magnitude
    logic                     r_d_valid;
    t_div_data                r_d_data;

    logic w_rdy_a, w_rdy_b, w_rdy_c, w_rdy_d;

    assign w_rdy_d = !r_d_valid || i_ready;
    assign w_rdy_c = !r_c_valid || w_rdy_d;
    assign w_rdy_b = !r_b_valid || w_rdy_c;
    assign w_rdy_a = !r_a_valid || w_rdy_b;
    assign o_ready = w_rdy_a;

    // stage a logic
    logic signed [AXIS_W-1:0] w_diff;
    logic signed [AXIS_W-1:0] w_trig;
    logic signed [AXIS_W-1:0] w_v;
    logic [AXIS_W:0]          w_mag;
    logic [MAG_W-1:0]         n_a_m;

    always_comb begin
        w_diff = $signed({1'b0, i_right_trigger}) - $signed({1'b0, i_left_trigger});
        // halve toward zero then double: drop odd unit toward zero
        if (w_diff[0]) begin
            w_trig = w_diff[AXIS_W-1] ? w_diff + 16'sd1 : w_diff - 16'sd1;
        end else begin
            w_trig = w_diff;
        end
        w_v   = i_mode ? w_trig : i_axis_value;
        w_mag = w_v[AXIS_W-1] ? -{w_v[AXIS_W-1], w_v} : {w_v[AXIS_W-1], w_v};
        n_a_m = w_mag[MAG_W] ? AXIS_FULL : w_mag[MAG_W-1:0];
    end

    // stage b logic
    logic [N_W-1:0]  w_mt;
    logic [N_W-1:0]  w_dt;
    logic [DZ_W-1:0] w_qd;
    logic [N_W-1:0]  w_q;

    always_comb begin
        w_mt = N_W'(r_a_m) * N_W'(DZ_FULL);
        w_dt = N_W'(i_dead_zone) * N_W'(AXIS_FULL);
        w_qd = DZ_FULL - i_dead_zone;
        w_q  = N_W'(w_qd) * N_W'(AXIS_FULL);
    end

    // stage c logic
    logic signed [SUM_W-1:0]  w_c;
    logic signed [SUM_W-1:0]  w_s;
    logic signed [PROD_W-1:0] w_cq;
    logic signed [PROD_W-1:0] w_ns;

    always_comb begin
        w_c  = SUM_W'(i_range_min) + SUM_W'(i_range_max);
        w_s  = SUM_W'(i_range_max) - SUM_W'(i_range_min);
        w_cq = PROD_W'(w_c) * PROD_W'($signed({1'b0, r_b_q}));
        w_ns = PROD_W'($signed({1'b0, r_b_n})) * PROD_W'(w_s);
    end

    // stage d logic
    logic signed [PROD_W-1:0] w_num;
    logic [PROD_W-1:0]        w_abs;

    always_comb begin
        w_num = r_c_neg ? r_c_p1 - r_c_p2 : r_c_p1 + r_c_p2;
        w_abs = w_num[PROD_W-1] ? -w_num : w_num;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            if (w_rdy_a) r_a_valid <= i_valid;
            if (w_rdy_b) r_b_valid <= r_a_valid;
            if (w_rdy_c) r_c_valid <= r_b_valid;
            if (w_rdy_d) r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_a) begin
            r_a_m   <= n_a_m;
            r_a_neg <= w_v[AXIS_W-1];
        end
        if (w_rdy_b) begin
            r_b_dead <= (w_mt <= w_dt);
            r_b_n    <= w_mt - w_dt;
            r_b_q    <= w_q;
            r_b_neg  <= r_a_neg;
        end
        if (w_rdy_c) begin
            // inside the dead zone the result is the centre: C / 2
            if (r_b_dead) begin
                r_c_p1  <= PROD_W'(w_c);
                r_c_p2  <= '0;
                r_c_div <= DIV_W'(2);
            end else begin
                r_c_p1  <= w_cq;
                r_c_p2  <= w_ns;
                r_c_div <= {r_b_q, 1'b0};
            end
            r_c_neg <= r_b_neg;
        end
        if (w_rdy_d) begin
            r_d_data.neg <= w_num[PROD_W-1];
            r_d_data.rem <= w_abs[REM_W-1:0];
            r_d_data.div <= r_c_div;
            r_d_data.quo <= '0;
        end
    end

    assign o_valid = r_d_valid;
    assign o_data  = r_d_data;

endmodule

// File: rtl/adzrs_div_cell.sv
// one restoring divider cell: resolves a single quotient bit
module adzrs_div_cell
    import adzrs_pkg::*;
#(
    parameter int BIT = 0
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_div_data i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_div_data o_data
);

    logic             r_valid;
    t_div_data        r_data;
    t_div_data        n_data;
    logic [REM_W-1:0] w_sub;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        w_sub  = REM_W'(i_data.div) << BIT;
        n_data = i_data;
        if (i_data.rem >= w_sub) begin
            n_data.rem = i_data.rem - w_sub;
            n_data.quo = i_data.quo | (QUO_W'(1) << BIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: rtl/axis_dead_zone_range_scaler.sv
// axis dead zone and range scaler top level: config registers, front stages, divider row
// pipeline: 4 front stages, 18 divider cells at one quotient bit each,
// 1 output register
// throughput: one transaction per cycle while i_m_axis_tready is not held low; every
// stage holds its own valid so a stalled output only blocks once the pipeline has filled
// reset (synchronous, active low): clears all stage valids and loads
// dead_zone = 0, range_min = -1000, range_max = 1000
module axis_dead_zone_range_scaler
    import adzrs_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [47:0]  i_s_axis_tdata,  // axis_value[15:0], left_trigger[30:16],
                                          // right_trigger[45:31], zero pad
    input  logic         i_s_axis_tuser,  // mode
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [23:0]  o_m_axis_tdata,  // scaled_axis[17:0], zero pad
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [17:0]  i_cfg_data
);

    logic [DZ_W-1:0]           r_dead_zone;
    logic signed [RANGE_W-1:0] r_range_min;
    logic signed [RANGE_W-1:0] r_range_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_zone <= '0;
            r_range_min <= -18'sd1000;
            r_range_max <= 18'sd1000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_DEAD_ZONE: r_dead_zone <= i_cfg_data[DZ_W-1:0];
                REG_RANGE_MIN: r_range_min <= $signed(i_cfg_data);
                REG_RANGE_MAX: r_range_max <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    logic      w_valid [0:QUO_W];
    logic      w_ready [0:QUO_W];
    t_div_data w_data  [0:QUO_W];

    adzrs_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_s_axis_tvalid),
        .o_ready         (o_s_axis_tready),
        .i_mode          (i_s_axis_tuser),
        .i_axis_value    ($signed(i_s_axis_tdata[15:0])),
        .i_left_trigger  (i_s_axis_tdata[30:16]),
        .i_right_trigger (i_s_axis_tdata[45:31]),
        .i_dead_zone     (r_dead_zone),
        .i_range_min     (r_range_min),
        .i_range_max     (r_range_max),
        .o_valid         (w_valid[0]),
        .i_ready         (w_ready[0]),
        .o_data          (w_data[0])
    );

    // cell k resolves quotient bit QUO_W-1-k, most significant first
    for (genvar k = 0; k < QUO_W; k++) begin : g_cell
        adzrs_div_cell #(
            .BIT (QUO_W - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_data  (w_data[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_data  (w_data[k+1])
        );
    end

    logic                      r_out_valid;
    logic signed [RANGE_W-1:0] r_out;
    logic [QUO_W-1:0]          w_quo;

    assign w_quo          = w_data[QUO_W].quo;
    assign w_ready[QUO_W] = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ready[QUO_W]) begin
            r_out_valid <= w_valid[QUO_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready[QUO_W]) begin
            r_out <= w_data[QUO_W].neg ? -$signed(w_quo) : $signed(w_quo);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out};

    // the last cell must leave a remainder below the divisor
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[QUO_W] |-> (w_data[QUO_W].rem < REM_W'(w_data[QUO_W].div)))
        else $error("divider remainder not below divisor");

    // result magnitude never exceeds QUO_MAX, the largest magnitude of an 18-bit signed range end
    a_quo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[QUO_W] |-> (w_quo <= QUO_MAX))
        else $error("quotient out of range");

    // divisor is never zero for a live transaction
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[0] |-> (w_data[0].div != '0))
        else $error("zero divisor entered divider");

    a_reset_clears_out: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_axis_tvalid)
        else $error("output valid after reset");

endmodule
